// ===== rtl/voxel_corner_occlusion_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for voxel_corner_occlusion
// Short forms for clocked assertions, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef VOXEL_CORNER_OCCLUSION_ASSERT_SVH
`define VOXEL_CORNER_OCCLUSION_ASSERT_SVH

// checked only out of reset
`define VCO_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VCO_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vco_pkg.sv =====
// ----------------------------------------------------------------------------
// vco_pkg
// Shared types, constants and corner tables of the voxel corner occlusion block.
// ----------------------------------------------------------------------------
`default_nettype none

package vco_pkg;

    localparam int VCO_SHADE_BITS = 10;
    localparam int CELL_COUNT     = 27;
    localparam int CELL_W         = 5;
    localparam int CENTRE_CELL    = 13;
    localparam int FACE_W         = 3;
    localparam int CORNER_W       = 2;
    localparam int LIGHT_W        = 4;
    localparam int LIGHT_SUM_W    = 6;
    localparam int OCC_W          = 11;
    localparam int BRIGHT_W       = 10;
    localparam int OCC_CAP        = 1024;
    localparam int SOURCE_LIGHT   = 600;
    localparam int LAST_FACE      = 5;
    localparam int LAST_CORNER    = 3;
    localparam int LAST_TAP       = 3;

    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_PUSH
    } vco_state_t;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic step;
        logic push;
        logic next;
    } vco_cmd_t;

    typedef struct packed {
        logic tap_done;
        logic run_done;
        logic slot_free;
    } vco_sts_t;

    // corner cell, side cell, side cell for each face/corner
    localparam logic [CELL_W-1:0] TRI_CELL [24][3] = '{
        '{5'd0,  5'd1,  5'd3},  '{5'd2,  5'd1,  5'd5},
        '{5'd6,  5'd3,  5'd7},  '{5'd8,  5'd5,  5'd7},
        '{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23},
        '{5'd24, 5'd21, 5'd25}, '{5'd26, 5'd23, 5'd25},
        '{5'd6,  5'd7,  5'd15}, '{5'd8,  5'd7,  5'd17},
        '{5'd24, 5'd15, 5'd25}, '{5'd26, 5'd17, 5'd25},
        '{5'd0,  5'd1,  5'd9},  '{5'd2,  5'd1,  5'd11},
        '{5'd18, 5'd9,  5'd19}, '{5'd20, 5'd11, 5'd19},
        '{5'd0,  5'd3,  5'd9},  '{5'd6,  5'd3,  5'd15},
        '{5'd18, 5'd9,  5'd21}, '{5'd24, 5'd15, 5'd21},
        '{5'd2,  5'd5,  5'd11}, '{5'd8,  5'd5,  5'd17},
        '{5'd20, 5'd11, 5'd23}, '{5'd26, 5'd17, 5'd23}
    };

    // the fourth shading cell is the face middle, shared by all four corners
    localparam logic [CELL_W-1:0] FACE_MID [6] = '{
        5'd4, 5'd22, 5'd16, 5'd10, 5'd12, 5'd14
    };

    // tap 0..2: corner and sides; tap 3: face middle
    function automatic logic [CELL_W-1:0] cell_at(
        input logic [FACE_W-1:0]   f,
        input logic [CORNER_W-1:0] c,
        input logic [1:0]          k
    );
        logic [CELL_W-1:0] addr;
        addr = '0;
        if (f <= FACE_W'(LAST_FACE))
        begin
            if (k == 2'(LAST_TAP))
                addr = FACE_MID[f];
            else
                addr = TRI_CELL[{f, c}][k];
        end
        return addr;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/voxel_corner_occlusion.sv =====
// ----------------------------------------------------------------------------
// voxel_corner_occlusion
// Per-corner ambient occlusion and light of a 3x3x3 voxel neighbourhood.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request loads one cell (cell_index,
// solid, light_level, shade); indexes above 26 write nothing. A request
// with last set loads its cell and then starts a run of 24 results,
// face-major, four corners per face; last_res marks the final one.
// Output channel (out_valid/out_ready) is backed by one output register.
// For each result the sequencer makes four single-port reads of the cell
// store (the corner, both sides and the face middle) and then pushes it.
// in_ready is low during a run and rises once the 24th result sits in the
// output register, while it still waits to be taken.
// A receiver stall holds the run in its push cycle; nothing is dropped.
// Reset clears the cell store to zeros (solid 0, light 0, shade 0), empties
// the output register and returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_corner_occlusion_assert.svh"

module voxel_corner_occlusion
    import vco_pkg::*;
#(
    parameter int SHADE_BITS = VCO_SHADE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CELL_W-1:0]     cell_index,
    input  wire logic                  solid,
    input  wire logic [LIGHT_W-1:0]    light_level,
    input  wire logic [SHADE_BITS-1:0] shade,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [FACE_W-1:0]          face,
    output logic [CORNER_W-1:0]        corner,
    output logic [OCC_W-1:0]           occlusion,
    output logic [BRIGHT_W-1:0]        brightness,
    output logic                       last_res
);

    vco_cmd_t cmd;
    vco_sts_t sts;

    vco_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vco_dp #(
        .SHADE_BITS (SHADE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cell_index  (cell_index),
        .solid       (solid),
        .light_level (light_level),
        .shade       (shade),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .face        (face),
        .corner      (corner),
        .occlusion   (occlusion),
        .brightness  (brightness),
        .last_res    (last_res)
    );

    `VCO_ASSERT(a_push_slot_free, cmd.push |-> sts.slot_free, "push into a full output register")
    `VCO_ASSERT(a_last_res_corner, (out_valid && last_res) |-> (face == FACE_W'(LAST_FACE) && corner == CORNER_W'(LAST_CORNER)), "last_res on wrong corner")
    `VCO_ASSERT(a_occ_capped, out_valid |-> (occlusion <= OCC_W'(OCC_CAP)), "occlusion above cap")
    `VCO_ASSERT(a_run_blocks_load, (in_valid && in_ready && last) |=> !in_ready, "load taken during a run")
    `VCO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown right after reset")

endmodule

`default_nettype wire

// ===== rtl/vco_ctrl.sv =====
// ----------------------------------------------------------------------------
// vco_ctrl
// Sequencer: cell loads, four-tap reads per corner, result push.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_ctrl
    import vco_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     last,
    output logic          in_ready,
    input  wire vco_sts_t sts,
    output vco_cmd_t      cmd
);

    vco_state_t state_reg;
    vco_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && last)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (sts.tap_done)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (sts.slot_free)
                    state_next = sts.run_done ? S_LOAD : S_READ;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.wr_en = in_valid;
                cmd.start = in_valid && last;
            end
            S_READ:
                cmd.step = 1'b1;
            S_PUSH:
            begin
                cmd.push = sts.slot_free;
                cmd.next = sts.slot_free && !sts.run_done;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/vco_dp.sv =====
// ----------------------------------------------------------------------------
// vco_dp
// Cell stores, tap accumulators, occlusion/brightness math, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_dp
    import vco_pkg::*;
#(
    parameter int SHADE_BITS = VCO_SHADE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vco_cmd_t              cmd,
    output vco_sts_t                   sts,
    input  wire logic [CELL_W-1:0]     cell_index,
    input  wire logic                  solid,
    input  wire logic [LIGHT_W-1:0]    light_level,
    input  wire logic [SHADE_BITS-1:0] shade,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [FACE_W-1:0]          face,
    output logic [CORNER_W-1:0]        corner,
    output logic [OCC_W-1:0]           occlusion,
    output logic [BRIGHT_W-1:0]        brightness,
    output logic                       last_res
);

    localparam int SACC_W = SHADE_BITS + 2;
    localparam int SUM_W  = (SHADE_BITS + 3 > OCC_W) ? SHADE_BITS + 3 : OCC_W;

    logic                solid_mem_reg [CELL_COUNT];
    logic [LIGHT_W-1:0]  light_mem_reg [CELL_COUNT];
    logic [SHADE_BITS-1:0] shade_mem_reg [CELL_COUNT];

    logic [FACE_W-1:0]      face_reg,   face_next;
    logic [CORNER_W-1:0]    corner_reg, corner_next;
    logic [1:0]             tap_reg,    tap_next;
    logic [SACC_W-1:0]      sacc_reg,   sacc_next;
    logic [LIGHT_SUM_W-1:0] lacc_reg,   lacc_next;
    logic [2:0]             sol_reg,    sol_next;

    logic                   out_valid_reg, out_valid_next;
    logic [FACE_W-1:0]      out_face_reg;
    logic [CORNER_W-1:0]    out_corner_reg;
    logic [OCC_W-1:0]       out_occ_reg;
    logic [BRIGHT_W-1:0]    out_bright_reg;
    logic                   out_last_reg;

    logic [CELL_W-1:0]      rd_addr;
    logic                   rd_solid;
    logic [LIGHT_W-1:0]     rd_light;
    logic [SHADE_BITS-1:0]  rd_shade;
    logic [1:0]             curve;
    logic [SUM_W-1:0]       occ_sum;
    logic [OCC_W-1:0]       occ_val;
    logic [BRIGHT_W-1:0]    bright_val;
    logic                   source;
    logic                   run_done;

    // cell stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                solid_mem_reg[i] <= 1'b0;
                light_mem_reg[i] <= '0;
                shade_mem_reg[i] <= '0;
            end
        end
        else if (cmd.wr_en && (cell_index < CELL_W'(CELL_COUNT)))
        begin
            solid_mem_reg[cell_index] <= solid;
            light_mem_reg[cell_index] <= light_level;
            shade_mem_reg[cell_index] <= shade;
        end
    end

    assign rd_addr  = cell_at(face_reg, corner_reg, tap_reg);
    assign rd_solid = solid_mem_reg[rd_addr];
    assign rd_light = light_mem_reg[rd_addr];
    assign rd_shade = shade_mem_reg[rd_addr];

    assign run_done = (face_reg == FACE_W'(LAST_FACE)) && (corner_reg == CORNER_W'(LAST_CORNER));

    // corner walk and tap accumulation
    always_comb
    begin
        face_next   = face_reg;
        corner_next = corner_reg;
        tap_next    = tap_reg;
        sacc_next   = sacc_reg;
        lacc_next   = lacc_reg;
        sol_next    = sol_reg;
        priority if (cmd.start)
        begin
            face_next   = '0;
            corner_next = '0;
            tap_next    = '0;
            sacc_next   = '0;
            lacc_next   = '0;
        end
        else if (cmd.step)
        begin
            tap_next  = tap_reg + 2'd1;
            sacc_next = sacc_reg + SACC_W'(rd_shade);
            lacc_next = lacc_reg + LIGHT_SUM_W'(rd_light);
            if (tap_reg != 2'(LAST_TAP))
                sol_next = {sol_reg[1:0], rd_solid};
        end
        else if (cmd.next)
        begin
            sacc_next   = '0;
            lacc_next   = '0;
            corner_next = corner_reg + CORNER_W'(1);
            if (corner_reg == CORNER_W'(LAST_CORNER))
                face_next = face_reg + FACE_W'(1);
        end
        else
            tap_next = tap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_reg   <= '0;
            corner_reg <= '0;
            tap_reg    <= '0;
        end
        else
        begin
            face_reg   <= face_next;
            corner_reg <= corner_next;
            tap_reg    <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sacc_reg <= sacc_next;
        lacc_reg <= lacc_next;
        sol_reg  <= sol_next;
    end

    // sol_reg: [2] corner, [1] side, [0] side
    always_comb
    begin
        if (sol_reg[1] && sol_reg[0])
            curve = 2'd3;
        else
            curve = 2'({1'b0, sol_reg[2]} + {1'b0, sol_reg[1]} + {1'b0, sol_reg[0]});
    end

    assign occ_sum = SUM_W'({curve, 8'b0}) + SUM_W'(sacc_reg);
    assign occ_val = (occ_sum > SUM_W'(OCC_CAP)) ? OCC_W'(OCC_CAP) : occ_sum[OCC_W-1:0];

    assign source     = light_mem_reg[CENTRE_CELL] == {LIGHT_W{1'b1}};
    assign bright_val = source ? BRIGHT_W'(SOURCE_LIGHT) : BRIGHT_W'(lacc_reg);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_face_reg   <= face_reg;
            out_corner_reg <= corner_reg;
            out_occ_reg    <= occ_val;
            out_bright_reg <= bright_val;
            out_last_reg   <= run_done;
        end
    end

    assign sts.tap_done  = tap_reg == 2'(LAST_TAP);
    assign sts.run_done  = run_done;
    assign sts.slot_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign face       = out_face_reg;
    assign corner     = out_corner_reg;
    assign occlusion  = out_occ_reg;
    assign brightness = out_bright_reg;
    assign last_res   = out_last_reg;

endmodule

`default_nettype wire
